### src/cslu_pkg.sv
// cslu_pkg: codes, character constants and helper functions for the
// string literal unescaper. No dependencies.
package cslu_pkg;

   // result kinds
   localparam logic [1:0] KIND_DATA   = 2'd0;
   localparam logic [1:0] KIND_END    = 2'd1;
   localparam logic [1:0] KIND_BADESC = 2'd2;
   localparam logic [1:0] KIND_BADRAW = 2'd3;

   // scan mode codes
   localparam logic [2:0] MODE_IDLE = 3'd0;
   localparam logic [2:0] MODE_TEXT = 3'd1;
   localparam logic [2:0] MODE_ESC  = 3'd2;
   localparam logic [2:0] MODE_HEX1 = 3'd3;
   localparam logic [2:0] MODE_HEX2 = 3'd4;

   // register map
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic        REG_QUOTE  = 1'b0;
   localparam logic [7:0]  QUOTE_RESET = 8'h22;

   // characters with a fixed meaning
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_APOS      = 8'h27;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_X         = 8'h78;
   localparam logic [7:0] CH_PRINT_LO  = 8'h20;
   localparam logic [7:0] CH_PRINT_HI  = 8'h7E;

   // hex digit decode: bit 4 set when the byte is a hex digit
   typedef logic [4:0] hex_digit_type;

   function automatic hex_digit_type hex_decode(input logic [7:0] c);
      logic [7:0] d;
      begin
         d = 8'h00;
         hex_decode = 5'b0_0000;
         if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
            hex_decode = {1'b1, d[3:0]};
         end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
            hex_decode = {1'b1, d[3:0]};
         end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
            hex_decode = {1'b1, d[3:0]};
         end
      end
   endfunction

   // simple escape decode: bit 8 set when the byte is a known escape letter
   typedef logic [8:0] esc_code_type;

   function automatic esc_code_type esc_decode(input logic [7:0] c);
      begin
         case (c)
            8'h6E: esc_decode = {1'b1, 8'h0A};
            8'h72: esc_decode = {1'b1, 8'h0D};
            8'h62: esc_decode = {1'b1, 8'h08};
            8'h74: esc_decode = {1'b1, 8'h09};
            8'h66: esc_decode = {1'b1, 8'h0C};
            8'h61: esc_decode = {1'b1, 8'h07};
            8'h76: esc_decode = {1'b1, 8'h0B};
            CH_DQUOTE, CH_APOS, CH_BACKSLASH: esc_decode = {1'b1, c};
            default: esc_decode = 9'h000;
         endcase
      end
   endfunction

endpackage

### src/c_string_literal_unescaper_top.sv
// c_string_literal_unescaper_top: byte-serial decoder for quoted literals.
// Depends on cslu_pkg for codes, constants and the digit/escape decoders.
//
// Usage:
//  - req channel: one source byte per word (req_byte_in), valid/ready.
//  - rsp channel: zero or one result word per source byte: decoded byte,
//    kind (data, end of literal, bad escape, illegal raw byte) and last,
//    set on end marker or error.
//  - csr port: APB-style, register 0 at address 0 is quote_char.
//  - a byte is taken into an input register, decoded against the scan
//    state once the output slot is free, and its result lands in the output
//    register, which drives rsp_valid.
//  - throughput one byte per cycle while rsp_ready stays high; the scan
//    state loop (mode and first hex nibble) updates once per decoded byte.
//  - opening quotes, backslashes and the x and first digit of a hex escape
//    give no result word.
//  - when the receiver stalls, the result holds in the output register and
//    one more byte waits in the input register; req_ready then drops.
//  - reset (synchronous, active high) empties both registers, returns the
//    scanner to idle and sets quote_char to a double quote.
module c_string_literal_unescaper_top
   import cslu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // source bytes
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_byte_in,
   // results
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_byte_out,
   output logic [1:0]            rsp_kind,
   output logic                  rsp_last,
   // configuration
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [7:0] quote_ff;
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic [2:0] mode_ff, mode_in;
   logic [3:0] nib_ff, nib_in;
   logic       rsp_valid_ff;
   logic [7:0] rsp_byte_ff;
   logic [1:0] rsp_kind_ff;
   logic       rsp_last_ff;

   logic         advance;
   logic         emit_in;
   logic [1:0]   kind_in;
   logic [7:0]   value_in;
   hex_digit_type hex_w;
   esc_code_type  esc_w;

   // configuration register
   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         quote_ff <= QUOTE_RESET;
      end else if (psel && penable && pwrite && paddr[2] == REG_QUOTE) begin
         quote_ff <= pwdata[7:0];
      end
   end
   assign prdata = (paddr[2] == REG_QUOTE) ? {{(CSR_DATA_W-8){1'b0}}, quote_ff}
                                           : '0;

   // handshake: decode moves a word on when the output slot is free
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff <= req_byte_in;
      end
   end

   // byte decode against the scan state
   assign hex_w = hex_decode(in_byte_ff);
   assign esc_w = esc_decode(in_byte_ff);

   always_comb begin
      mode_in  = mode_ff;
      nib_in   = nib_ff;
      emit_in  = 1'b0;
      kind_in  = KIND_DATA;
      value_in = 8'h00;
      case (mode_ff)
         MODE_TEXT: begin
            // quote check comes before every other byte rule
            if (in_byte_ff == quote_ff) begin
               emit_in = 1'b1;
               kind_in = KIND_END;
            end else if (in_byte_ff == CH_BACKSLASH) begin
               mode_in = MODE_ESC;
            end else if (in_byte_ff inside {[CH_PRINT_LO:CH_PRINT_HI]} &&
                         in_byte_ff != CH_DQUOTE) begin
               emit_in  = 1'b1;
               value_in = in_byte_ff;
            end else begin
               emit_in = 1'b1;
               kind_in = KIND_BADRAW;
            end
         end
         MODE_ESC: begin
            mode_in = MODE_TEXT;
            if (esc_w[8]) begin
               emit_in  = 1'b1;
               value_in = esc_w[7:0];
            end else if (in_byte_ff == CH_X) begin
               mode_in = MODE_HEX1;
            end else begin
               emit_in = 1'b1;
               kind_in = KIND_BADESC;
            end
         end
         MODE_HEX1: begin
            if (hex_w[4]) begin
               nib_in  = hex_w[3:0];
               mode_in = MODE_HEX2;
            end else begin
               emit_in = 1'b1;
               kind_in = KIND_BADESC;
            end
         end
         MODE_HEX2: begin
            if (hex_w[4]) begin
               emit_in  = 1'b1;
               value_in = {nib_ff, hex_w[3:0]};
               mode_in  = MODE_TEXT;
               nib_in   = 4'h0;
            end else begin
               emit_in = 1'b1;
               kind_in = KIND_BADESC;
            end
         end
         default: begin
            // idle and unused codes: wait for the opening quote
            mode_in = (in_byte_ff == quote_ff) ? MODE_TEXT : MODE_IDLE;
         end
      endcase
      // end marker and errors close the run
      if (emit_in && kind_in != KIND_DATA) begin
         mode_in = MODE_IDLE;
         nib_in  = 4'h0;
      end
   end

   // scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         nib_ff  <= 4'h0;
      end else if (advance) begin
         mode_ff <= mode_in;
         nib_ff  <= nib_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= emit_in;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_byte_ff <= (kind_in == KIND_DATA) ? value_in : 8'h00;
         rsp_kind_ff <= kind_in;
         rsp_last_ff <= (kind_in != KIND_DATA);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_byte_out = rsp_byte_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_last     = rsp_last_ff;

   // checks
   a_last_matches_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_last_ff == (rsp_kind_ff != KIND_DATA)))
      else $error("last flag disagrees with kind");

   a_zero_byte_on_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff != KIND_DATA |-> rsp_byte_ff == 8'h00)
      else $error("non-data word carries a byte");

   a_held_word_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("waiting source byte lost");

   a_error_returns_idle: assert property (@(posedge clock) disable iff (reset)
      advance && emit_in && kind_in != KIND_DATA |=> mode_ff == MODE_IDLE)
      else $error("scanner not idle after end or error");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> mode_ff == MODE_IDLE && !rsp_valid_ff && !in_valid_ff)
      else $error("reset did not clear control state");

endmodule

### sim/cslu_checker.sv
// cslu_checker: watches the byte, result and register ports of the literal
// unescaper, predicts every result word and compares it with the block's.
// Depends on cslu_pkg for result kinds, scan mode codes and characters.
module cslu_checker
   import cslu_pkg::*;
#(
   parameter logic [CSR_ADDR_W-1:0] QUOTE_ADDR = '0
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [7:0]            req_byte_in,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [7:0]            rsp_byte_out,
   input  logic [1:0]            rsp_kind,
   input  logic                  rsp_last,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output int unsigned           mismatches,
   output int unsigned           words_pending
);

   typedef struct packed {
      logic [7:0] data;
      logic [1:0] kind;
      logic       last;
   } lit_word_t;

   // shadow of the register and the scanner state
   logic [7:0] quote_q;
   logic [2:0] mode_q;
   logic [3:0] nibble_q;
   lit_word_t  expected_words[$];

   // bit 4 flags a hex digit, low bits give its value
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      if (c >= "0" && c <= "9") return {1'b1, c[3:0]};
      if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) return {1'b1, c[3:0] + 4'd9};
      return 5'b0;
   endfunction

   // advance the scanner by one byte, queueing the word it gives if any
   task automatic unescape_byte(input logic [7:0] c);
      lit_word_t  w;
      logic [4:0] h;
      logic       has_word;
      w        = '0;
      has_word = 1'b0;
      h        = hex_nibble(c);
      case (mode_q)
         MODE_TEXT: begin
            // the quote wins over every other rule, backslash included
            if (c == quote_q) begin
               has_word = 1'b1;
               w.kind   = KIND_END;
            end else if (c == CH_BACKSLASH) begin
               mode_q = MODE_ESC;
            end else if (c >= CH_PRINT_LO && c <= CH_PRINT_HI && c != CH_DQUOTE) begin
               has_word = 1'b1;
               w.kind   = KIND_DATA;
               w.data   = c;
            end else begin
               has_word = 1'b1;
               w.kind   = KIND_BADRAW;
            end
         end
         MODE_ESC: begin
            // escape text, even when it matches the quote
            mode_q   = MODE_TEXT;
            has_word = 1'b1;
            w.kind   = KIND_DATA;
            case (c)
               "n": w.data = 8'h0A;
               "r": w.data = 8'h0D;
               "b": w.data = 8'h08;
               "t": w.data = 8'h09;
               "f": w.data = 8'h0C;
               "a": w.data = 8'h07;
               "v": w.data = 8'h0B;
               CH_DQUOTE, CH_APOS, CH_BACKSLASH: w.data = c;
               CH_X: begin
                  mode_q   = MODE_HEX1;
                  has_word = 1'b0;
               end
               default: w.kind = KIND_BADESC;
            endcase
         end
         MODE_HEX1: begin
            if (h[4]) begin
               nibble_q = h[3:0];
               mode_q   = MODE_HEX2;
            end else begin
               has_word = 1'b1;
               w.kind   = KIND_BADESC;
            end
         end
         MODE_HEX2: begin
            has_word = 1'b1;
            if (h[4]) begin
               w.kind   = KIND_DATA;
               w.data   = {nibble_q, h[3:0]};
               nibble_q = 4'd0;
               mode_q   = MODE_TEXT;
            end else begin
               w.kind = KIND_BADESC;
            end
         end
         // idle and unused codes: wait for an opening quote
         default: mode_q = (c == quote_q) ? MODE_TEXT : MODE_IDLE;
      endcase
      if (has_word) begin
         // end marker and errors close the run and drop back to idle
         if (w.kind != KIND_DATA) begin
            w.data   = 8'h00;
            w.last   = 1'b1;
            mode_q   = MODE_IDLE;
            nibble_q = 4'd0;
         end
         expected_words = {expected_words, w};
      end
   endtask

   // track register writes and bytes, compare result words in order
   always @(posedge clock) begin
      lit_word_t got;
      lit_word_t want;
      logic      bad;
      if (reset) begin
         quote_q  = QUOTE_RESET;
         mode_q   = MODE_IDLE;
         nibble_q = 4'd0;
         expected_words.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr == QUOTE_ADDR)
            quote_q = pwdata[7:0];
         if (req_valid && req_ready)
            unescape_byte(req_byte_in);
         if (rsp_valid && rsp_ready) begin
            got = '{data: rsp_byte_out, kind: rsp_kind, last: rsp_last};
            if (expected_words.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result word: byte=%02h kind=%0d last=%0b",
                           got.data, got.kind, got.last);
            end else begin
               want = expected_words.pop_front();
               bad  = (got.data !== want.data) || (got.kind !== want.kind) ||
                      (got.last !== want.last);
               if (bad) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("word mismatch: expected byte=%02h kind=%0d last=%0b, got byte=%02h kind=%0d last=%0b",
                              want.data, want.kind, want.last,
                              got.data, got.kind, got.last);
               end
            end
         end
      end
      words_pending = expected_words.size();
   end

endmodule

### sim/tb_c_string_literal_unescaper_top.sv
// tb_c_string_literal_unescaper_top: drives bytes, register writes and result
// back-pressure into the unescaper and gives the verdict.
// Depends on cslu_pkg, c_string_literal_unescaper_top and cslu_checker.
module tb_c_string_literal_unescaper_top;
   import cslu_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] QUOTE_ADDR = CSR_ADDR_W'(4 * REG_QUOTE);
   localparam int unsigned PHASE_BYTES = 200;
   localparam int unsigned HOLD_CYCLES = 160;
   localparam int unsigned STALL_LIMIT = 1000;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [7:0]            req_byte_in;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [7:0]            rsp_byte_out;
   logic [1:0]            rsp_kind;
   logic                  rsp_last;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int unsigned mismatches;
   int unsigned words_pending;
   int unsigned bytes_sent;
   int unsigned quiet_cycles;
   logic        tx_idle_on;
   logic        rx_idle_on;
   logic        hold_request;
   logic [7:0]  cur_quote;
   logic [7:0]  quote_plan [0:6];

   // opening run: ignored bytes, edge printables, escapes, each error path
   logic [7:0] directed_bytes [0:31] = '{
      8'h51, 8'h22, 8'h20, 8'h7E, 8'h27, 8'h5C, 8'h6E, 8'h5C,
      8'h22, 8'h5C, 8'h78, 8'h46, 8'h66, 8'h5C, 8'h78, 8'h30,
      8'h30, 8'h22, 8'h22, 8'h5C, 8'h71, 8'h22, 8'h5C, 8'h78,
      8'h67, 8'h22, 8'h5C, 8'h78, 8'h39, 8'h5A, 8'h22, 8'h7F
   };

   c_string_literal_unescaper_top u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_byte_in  (req_byte_in),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_byte_out (rsp_byte_out),
      .rsp_kind     (rsp_kind),
      .rsp_last     (rsp_last),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready)
   );

   cslu_checker #(.QUOTE_ADDR(QUOTE_ADDR)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_byte_in   (req_byte_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_byte_out  (rsp_byte_out),
      .rsp_kind      (rsp_kind),
      .rsp_last      (rsp_last),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .pready        (pready),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .mismatches    (mismatches),
      .words_pending (words_pending)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // result side: random stalls, or one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_ready <= !rx_idle_on || ($urandom_range(99) >= 34);
         end
      end
   end

   // watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_c_string_literal_unescaper_top: errors");
         $finish;
      end
   end

   // offer one byte, with an optional gap first, and wait for acceptance
   task automatic push_byte(input logic [7:0] b);
      while (tx_idle_on && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_byte_in <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   // stop sending, let every expected word arrive, then let the pipe empty
   task automatic await_idle(input int unsigned settle);
      req_valid <= 1'b0;
      while (words_pending != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   // register write: setup then access cycle, upper data bits random
   task automatic write_quote(input logic [7:0] q);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= QUOTE_ADDR;
      pwdata  <= {24'($urandom()), q};
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      cur_quote = q;
   endtask

   // one literal: mostly well formed with random content, some broken
   task automatic send_random_literal();
      string       hex_digits;
      string       esc_letters;
      logic [7:0]  b;
      int unsigned len;
      int unsigned pick;
      hex_digits  = "0123456789abcdefABCDEF";
      esc_letters = "nrbtfav\"'\\";
      // pure noise
      if ($urandom_range(99) < 8) begin
         repeat ($urandom_range(1, 6)) push_byte(8'($urandom()));
         return;
      end
      if ($urandom_range(3) == 0)
         push_byte(8'($urandom()));
      push_byte(cur_quote);
      len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(10);
      repeat (len) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            do b = 8'($urandom_range(8'h20, 8'h7E));
            while (b == cur_quote || b == CH_DQUOTE || b == CH_BACKSLASH);
            push_byte(b);
         end else if (pick < 75) begin
            push_byte(CH_BACKSLASH);
            push_byte(esc_letters[$urandom_range(9)]);
         end else if (pick < 90) begin
            push_byte(CH_BACKSLASH);
            push_byte(CH_X);
            push_byte(hex_digits[$urandom_range(21)]);
            push_byte(hex_digits[$urandom_range(21)]);
         end else if (pick < 93) begin
            push_byte(CH_BACKSLASH);
            push_byte(8'($urandom()));
         end else if (pick < 96) begin
            push_byte(CH_BACKSLASH);
            push_byte(CH_X);
            push_byte(8'($urandom()));
            push_byte(8'($urandom()));
         end else begin
            // control codes, delete, high bytes or a stray double quote
            case ($urandom_range(3))
               0:       b = 8'($urandom_range(8'h1F));
               1:       b = 8'h7F;
               2:       b = 8'($urandom_range(8'h80, 8'hFF));
               default: b = CH_DQUOTE;
            endcase
            push_byte(b);
         end
      end
      if ($urandom_range(9) != 0)
         push_byte(cur_quote);
   endtask

   // stimulus and verdict
   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_byte_in  = 8'h00;
      psel         = 1'b0;
      penable      = 1'b0;
      pwrite       = 1'b0;
      paddr        = '0;
      pwdata       = '0;
      tx_idle_on   = 1'b1;
      rx_idle_on   = 1'b1;
      hold_request = 1'b0;
      bytes_sent   = 0;
      quiet_cycles = 0;
      cur_quote    = QUOTE_RESET;
      quote_plan   = '{QUOTE_RESET, CH_APOS, CH_BACKSLASH, 8'h00, 8'hFF,
                       8'($urandom()), CH_DQUOTE};
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_bytes[i]) push_byte(directed_bytes[i]);

      for (int p = 0; p < 7; p++) begin
         await_idle(4);
         if (p != 0) write_quote(quote_plan[p]);
         // one phase runs with no idling on either side
         tx_idle_on = (p != 1);
         rx_idle_on = (p != 1);
         if (p == 0) begin
            // long receiver hold-off while data bytes keep coming
            hold_request = 1'b1;
            push_byte(cur_quote);
            repeat (24) push_byte(8'($urandom_range(8'h41, 8'h7A)));
            push_byte(cur_quote);
         end
         while (bytes_sent < (p + 1) * PHASE_BYTES + 32)
            send_random_literal();
      end

      await_idle(8);
      if (mismatches == 0 && words_pending == 0)
         $display("tb_c_string_literal_unescaper_top: clean");
      else
         $display("tb_c_string_literal_unescaper_top: errors");
      $finish;
   end

endmodule
